// ----- src/piecewise_linear_colour_map_defines.svh -----
// ----------------------------------------------------------------------------
// Colour map assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_COLOUR_MAP_DEFINES_SVH
`define PIECEWISE_LINEAR_COLOUR_MAP_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a property on every clock edge outside reset.
`define PLCM_ASSERT(name_, prop_, msg_) \
  name_: assert property (@(posedge clk_i) disable iff (!rst_ni) prop_) \
    else $error(msg_);
// Checks that a condition never holds outside reset.
`define PLCM_ASSERT_NEVER(name_, cond_, msg_) \
  name_: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond_)) \
    else $error(msg_);
`else
`define PLCM_ASSERT(name_, prop_, msg_)
`define PLCM_ASSERT_NEVER(name_, cond_, msg_)
`endif

`endif

// ----- src/plcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour map package
// Shared widths, defaults, controller states and control structs.
// ----------------------------------------------------------------------------
package plcm_pkg;

  localparam int MaxPointsDef    = 16;
  localparam int FractionBitsDef = 16;

  localparam int KeyW    = 32;
  localparam int ChanW   = 8;
  localparam int ColourW = 4 * ChanW;
  localparam int IndexW  = 4;
  localparam int CountW  = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_BLEND
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic write;
    logic scan;
    logic hit_mid;
    logic take_cur;
    logic div_step;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic key_gt;
    logic is_first;
    logic is_last;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

// ----- src/plcm_lookup_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour map request channel
// Carries point writes and lookups with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface plcm_lookup_if;
  import plcm_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [IndexW-1:0] entry_index;
  logic signed [KeyW-1:0] key_or_value;
  logic [ChanW-1:0]  in_red;
  logic [ChanW-1:0]  in_green;
  logic [ChanW-1:0]  in_blue;
  logic [ChanW-1:0]  in_alpha;

  modport source (
    output valid, op, entry_index, key_or_value, in_red, in_green, in_blue, in_alpha,
    input  ready
  );

  modport sink (
    input  valid, op, entry_index, key_or_value, in_red, in_green, in_blue, in_alpha,
    output ready
  );

endinterface

// ----- src/plcm_colour_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour map result channel
// Carries one RGBA colour per lookup with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface plcm_colour_if;
  import plcm_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] out_red;
  logic [ChanW-1:0] out_green;
  logic [ChanW-1:0] out_blue;
  logic [ChanW-1:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );

endinterface

// ----- src/plcm_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour map configuration channel
// Writes the point count register with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface plcm_cfg_if;
  import plcm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] point_count;

  modport source (
    output valid, point_count,
    input  ready
  );

  modport sink (
    input  valid, point_count,
    output ready
  );

endinterface

// ----- src/piecewise_linear_colour_map.sv -----
`timescale 1ns / 1ps
// A point write gives no result. A lookup scans the keys in slot order, one key
// read per cycle from the point memory; only between two points does it then run
// the one-bit-per-cycle divider for FRACTION_BITS quotient bits. It then blends the
// colour and emits it once the output register is free.
// Reset clears the controller, the output valid flag and sets point_count to one;
// the point memory is not cleared and holds unknown data until each slot is written.
// ----------------------------------------------------------------------------
// Piecewise linear colour map
// Maps a Q16.16 value to an RGBA colour by interpolating between control points.
// ----------------------------------------------------------------------------
`include "piecewise_linear_colour_map_defines.svh"

module piecewise_linear_colour_map import plcm_pkg::*; #(
  parameter int MAX_POINTS    = MaxPointsDef,
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  plcm_lookup_if.sink   lookup_req_i,
  plcm_cfg_if.sink      cfg_req_i,
  plcm_colour_if.source colour_rsp_o
);

  // The controller steps the datapath through the scan, the division and the
  // blend. Only commands and status pass between the two.
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  out_valid;
  logic [ColourW-1:0] out_colour;

  // The count register can be written at any time; it is only sampled when a
  // lookup starts.
  assign cfg_req_i.ready = 1'b1;

  plcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (lookup_req_i.valid),
    .in_op_i    (lookup_req_i.op),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  assign lookup_req_i.ready = in_ready;

  // Colours are packed red in the low byte up to alpha in the high byte.
  plcm_datapath #(
    .MAX_POINTS    (MAX_POINTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_req_i.valid),
    .cfg_count_i    (cfg_req_i.point_count),
    .entry_index_i  (lookup_req_i.entry_index),
    .key_or_value_i (lookup_req_i.key_or_value),
    .in_colour_i    ({lookup_req_i.in_alpha, lookup_req_i.in_blue,
                      lookup_req_i.in_green, lookup_req_i.in_red}),
    .out_valid_o    (out_valid),
    .out_ready_i    (colour_rsp_o.ready),
    .out_colour_o   (out_colour)
  );

  // The output register decouples the result from the next request, so a
  // new request is taken while a finished colour still waits.
  assign colour_rsp_o.valid     = out_valid;
  assign colour_rsp_o.out_red   = out_colour[7:0];
  assign colour_rsp_o.out_green = out_colour[15:8];
  assign colour_rsp_o.out_blue  = out_colour[23:16];
  assign colour_rsp_o.out_alpha = out_colour[31:24];

  // A result is only loaded when the output register is free or being drained.
  `PLCM_ASSERT(a_emit_when_free, cmd.emit |-> stat.out_free, "result loaded over a pending one")

  // A lookup keeps the request side busy on the following cycle.
  `PLCM_ASSERT(a_lookup_busy, (lookup_req_i.valid && lookup_req_i.ready && lookup_req_i.op) |=> !lookup_req_i.ready, "request taken during a lookup")

  // A point write never produces a result.
  `PLCM_ASSERT(a_write_silent, (lookup_req_i.valid && lookup_req_i.ready && !lookup_req_i.op && !colour_rsp_o.valid) |=> !colour_rsp_o.valid, "result after a point write")

  // The scan and the divider never run in the same cycle.
  `PLCM_ASSERT_NEVER(a_scan_div_excl, cmd.scan && cmd.div_step, "scan and divide overlap")

endmodule

// ----- src/plcm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plcm_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/plcm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour map controller
// Sequences point writes, the key scan, the divider and the blend.
// ----------------------------------------------------------------------------
module plcm_ctrl import plcm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_op_i,
  output logic  in_ready_o,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.key_gt && !stat_i.is_first) begin
          cmd_o.hit_mid = 1'b1;
          state_d       = ST_DIV;
        end else if (stat_i.key_gt || stat_i.is_last) begin
          cmd_o.take_cur = 1'b1;
          state_d        = ST_BLEND;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/plcm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour map datapath
// Point memory, key scan registers, restoring divider and channel blend.
// ----------------------------------------------------------------------------
module plcm_datapath import plcm_pkg::*; #(
  parameter int MAX_POINTS    = MaxPointsDef,
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic                   cfg_we_i,
  input  logic [CountW-1:0]      cfg_count_i,
  input  logic [IndexW-1:0]      entry_index_i,
  input  logic signed [KeyW-1:0] key_or_value_i,
  input  logic [ColourW-1:0]     in_colour_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ColourW-1:0]     out_colour_o
);

  localparam int AddrW = $clog2(MAX_POINTS);
  localparam int CntW  = $clog2(FRACTION_BITS);
  localparam int ProdW = FRACTION_BITS + 11;
  localparam logic signed [ProdW-1:0] HalfLsb = ProdW'(1) << (FRACTION_BITS - 1);

  logic [CountW-1:0]        count_q;
  logic [AddrW-1:0]         last_idx;
  logic [AddrW-1:0]         last_idx_q;
  logic [AddrW-1:0]         idx_q;
  logic [AddrW-1:0]         raddr;
  logic                     ram_we;
  logic [KeyW+ColourW-1:0]  rdata;
  logic signed [KeyW-1:0]   cur_key;
  logic [ColourW-1:0]       cur_col;
  logic signed [KeyW-1:0]   v_q;
  logic signed [KeyW-1:0]   prev_key_q;
  logic [ColourW-1:0]       prev_col_q;
  logic [ColourW-1:0]       hi_col_q;
  logic [KeyW-1:0]          rem_q;
  logic [KeyW-1:0]          span_q;
  logic [FRACTION_BITS-1:0] pos_q;
  logic [CntW-1:0]          div_cnt_q;
  logic [KeyW:0]            rem_x2;
  logic                     rem_ge;
  logic signed [9:0]        diff  [4];
  logic signed [ProdW-1:0]  prod  [4];
  logic [ChanW-1:0]         chan  [4];
  logic [ColourW-1:0]       blend_col;
  logic                     out_vld_q;
  logic [ColourW-1:0]       out_col_q;

  // Point count register; zero means one point and large values saturate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(1);
    end else if (cfg_we_i) begin
      count_q <= cfg_count_i;
    end
  end

  always_comb begin
    if (count_q == '0) begin
      last_idx = '0;
    end else if (int'(count_q) > MAX_POINTS) begin
      last_idx = AddrW'(MAX_POINTS - 1);
    end else begin
      last_idx = AddrW'(count_q - CountW'(1));
    end
  end

  // Point memory holds {key, colour}; a lookup starts reading slot zero.
  assign ram_we = cmd_i.write && (int'(entry_index_i) < MAX_POINTS);
  assign raddr  = cmd_i.start ? '0 : idx_q + AddrW'(1);

  plcm_ram #(
    .Width (KeyW + ColourW),
    .Depth (MAX_POINTS)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(entry_index_i)),
    .wdata_i ({key_or_value_i, in_colour_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cur_key = $signed(rdata[KeyW+ColourW-1:ColourW]);
  assign cur_col = rdata[ColourW-1:0];

  // One radix-2 restoring step; the remainder always stays below the span.
  assign rem_x2 = {rem_q, 1'b0};
  assign rem_ge = rem_x2 >= {1'b0, span_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      v_q        <= key_or_value_i;
      last_idx_q <= last_idx;
      idx_q      <= '0;
    end
    if (cmd_i.scan) begin
      prev_key_q <= cur_key;
      prev_col_q <= cur_col;
      idx_q      <= idx_q + AddrW'(1);
    end
    if (cmd_i.hit_mid) begin
      hi_col_q  <= cur_col;
      rem_q     <= KeyW'(v_q - prev_key_q);
      span_q    <= KeyW'(cur_key - prev_key_q);
      pos_q     <= '0;
      div_cnt_q <= CntW'(FRACTION_BITS - 1);
    end
    if (cmd_i.take_cur) begin
      prev_col_q <= cur_col;
      hi_col_q   <= cur_col;
      pos_q      <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q     <= rem_ge ? KeyW'(rem_x2 - {1'b0, span_q}) : KeyW'(rem_x2);
      pos_q     <= {pos_q[FRACTION_BITS-2:0], rem_ge};
      div_cnt_q <= div_cnt_q - CntW'(1);
    end
    if (cmd_i.emit) begin
      out_col_q <= blend_col;
    end
  end

  // Each channel: lo + floor(((hi - lo) * pos + half) / 2^F), kept mod 256.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      diff[c] = $signed({2'b00, hi_col_q[ChanW*c +: ChanW]})
              - $signed({2'b00, prev_col_q[ChanW*c +: ChanW]});
      prod[c] = diff[c] * $signed({1'b0, pos_q}) + HalfLsb;
      chan[c] = prev_col_q[ChanW*c +: ChanW] + prod[c][FRACTION_BITS +: ChanW];
    end
    blend_col = {chan[3], chan[2], chan[1], chan[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_colour_o = out_col_q;

  assign stat_o.key_gt   = cur_key > v_q;
  assign stat_o.is_first = idx_q == '0;
  assign stat_o.is_last  = idx_q == last_idx_q;
  assign stat_o.div_last = div_cnt_q == '0;
  assign stat_o.out_free = !out_vld_q || out_ready_i;

endmodule

// ----- tb/piecewise_linear_colour_map_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour map testbench
// Loads control points, sets the point count and checks every looked-up colour
// against a fixed-point interpolation predictor, under random idling on both sides.
// ----------------------------------------------------------------------------
module piecewise_linear_colour_map_tb;
  import plcm_pkg::*;

  // Opcodes carried in the op field of a request.
  typedef enum logic {
    OP_WRITE_POINT = 1'b0,
    OP_LOOKUP      = 1'b1
  } plcm_op_e;

  // One request on the lookup channel, either a point write or a lookup.
  typedef struct packed {
    plcm_op_e               op;
    logic [IndexW-1:0]      slot;
    logic signed [KeyW-1:0] key;
    logic [ChanW-1:0]       red;
    logic [ChanW-1:0]       green;
    logic [ChanW-1:0]       blue;
    logic [ChanW-1:0]       alpha;
  } point_req_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } rgba_t;

  localparam int          NUM_PHASES      = 10;
  localparam int          PHASE_ROLLS     = 81;
  localparam int          PRESSURE_PHASE  = 2;
  localparam int          PRESSURE_CYCLES = 300;
  // Settle time that covers any write still in flight when the last colour
  // of a phase has come back.
  localparam int          SETTLE_CYCLES   = 64;
  localparam int          CYCLE_LIMIT     = 500000;
  localparam logic signed [KeyW-1:0] KEY_MIN = {1'b1, {(KeyW-1){1'b0}}};
  localparam logic signed [KeyW-1:0] KEY_MAX = {1'b0, {(KeyW-1){1'b1}}};

  logic clk_i;
  logic rst_ni;

  plcm_lookup_if lookup_bus ();
  plcm_cfg_if    cfg_bus ();
  plcm_colour_if colour_bus ();

  piecewise_linear_colour_map DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lookup_req_i (lookup_bus),
    .cfg_req_i    (cfg_bus),
    .colour_rsp_o (colour_bus)
  );

  // Requests waiting to be offered, and colours waiting to come back.
  point_req_t pending_points[$];
  rgba_t      expected_colours[$];
  point_req_t offered_req;

  // Predictor state: the point table and count as the block should hold them.
  logic signed [KeyW-1:0] model_key [MaxPointsDef];
  rgba_t                  model_rgba [MaxPointsDef];
  logic [CountW-1:0]      model_count;

  // Generator view of the table, used to shape lookups and to make sure that
  // every slot a lookup can reach has been written first.
  logic signed [KeyW-1:0] plan_key [MaxPointsDef];
  bit                     plan_written [MaxPointsDef];

  logic [CountW-1:0] phase_counts [NUM_PHASES];

  bit no_idle;
  bit pressure_armed;
  bit hold_rsp;
  int send_gap;
  int stall_left;
  int error_count;
  int writes_done;
  int lookups_done;
  int colours_checked;
  int settings_done;
  int cycle_count;

  // --------------------------------------------------------------------------
  // Clock, reset and watchdog
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The limit allows every request a full lookup, a worst sender gap and a
  // worst receiver stall, several times over.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d colours outstanding.", cycle_count,
               expected_colours.size());
      $display("piecewise_linear_colour_map verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // A count of zero means one point and anything above the table size
  // saturates to the table size.
  function automatic int unsigned points_in_use(input logic [CountW-1:0] count);
    if (count == 0) return 1;
    if (count > MaxPointsDef) return MaxPointsDef;
    return count;
  endfunction

  // One channel: lo + floor(((hi - lo) * pos + half) / 2^FRACTION_BITS).
  // The arithmetic shift of a signed longint gives the floor for negative
  // products as well.
  function automatic logic [ChanW-1:0] blend_channel(input logic [ChanW-1:0] lo_c,
                                                     input logic [ChanW-1:0] hi_c,
                                                     input longint pos);
    longint t;
    t = (longint'(hi_c) - longint'(lo_c)) * pos + (longint'(1) << (FractionBitsDef - 1));
    return ChanW'(longint'(lo_c) + (t >>> FractionBitsDef));
  endfunction

  // Scans the points in slot order for the first key strictly above the
  // value. Below the first key or past the last one the colour is taken as is;
  // otherwise it is interpolated between the two neighbouring points.
  function automatic rgba_t interpolate_colour(input logic signed [KeyW-1:0] value);
    int unsigned n;
    int unsigned hit;
    bit          found;
    longint      k_lo;
    longint      k_hi;
    longint      pos;
    rgba_t       lo_c;
    rgba_t       hi_c;
    rgba_t       res;
    n     = points_in_use(model_count);
    hit   = 0;
    found = 1'b0;
    while (!found && hit < n) begin
      if (model_key[hit] > value) found = 1'b1;
      else hit++;
    end
    if (!found) return model_rgba[n-1];
    if (hit == 0) return model_rgba[0];
    k_lo = model_key[hit-1];
    k_hi = model_key[hit];
    pos  = ((longint'(value) - k_lo) << FractionBitsDef) / (k_hi - k_lo);
    lo_c = model_rgba[hit-1];
    hi_c = model_rgba[hit];
    res.red   = blend_channel(lo_c.red, hi_c.red, pos);
    res.green = blend_channel(lo_c.green, hi_c.green, pos);
    res.blue  = blend_channel(lo_c.blue, hi_c.blue, pos);
    res.alpha = blend_channel(lo_c.alpha, hi_c.alpha, pos);
    return res;
  endfunction

  // Applies an accepted request to the predictor state.
  task automatic absorb_request(input point_req_t req);
    rgba_t colour;
    if (req.op == OP_WRITE_POINT) begin
      model_key[req.slot] = req.key;
      colour.red   = req.red;
      colour.green = req.green;
      colour.blue  = req.blue;
      colour.alpha = req.alpha;
      model_rgba[req.slot] = colour;
      writes_done++;
    end else begin
      expected_colours.push_back(interpolate_colour(req.key));
      lookups_done++;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Channel values lean toward the two extremes now and then.
  function automatic logic [ChanW-1:0] random_channel();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return ChanW'($urandom);
  endfunction

  task automatic push_write(input int unsigned slot, input logic signed [KeyW-1:0] key,
                            input logic [ChanW-1:0] red, input logic [ChanW-1:0] green,
                            input logic [ChanW-1:0] blue, input logic [ChanW-1:0] alpha);
    point_req_t req;
    req.op    = OP_WRITE_POINT;
    req.slot  = IndexW'(slot);
    req.key   = key;
    req.red   = red;
    req.green = green;
    req.blue  = blue;
    req.alpha = alpha;
    pending_points.push_back(req);
    plan_key[slot]     = key;
    plan_written[slot] = 1'b1;
  endtask

  task automatic push_lookup(input logic signed [KeyW-1:0] value);
    point_req_t req;
    req       = '0;
    req.op    = OP_LOOKUP;
    req.slot  = IndexW'($urandom);
    req.key   = value;
    req.red   = ChanW'($urandom);
    req.green = ChanW'($urandom);
    req.blue  = ChanW'($urandom);
    req.alpha = ChanW'($urandom);
    pending_points.push_back(req);
  endtask

  // A write to any slot with any key, so that the table is sometimes left
  // with keys out of order.
  task automatic push_random_write();
    push_write($urandom_range(0, MaxPointsDef - 1), KeyW'($urandom), random_channel(),
               random_channel(), random_channel(), random_channel());
  endtask

  // Rewrites the points in use with strictly ascending keys. The spacing
  // scale is random, from neighbours one apart up to very wide spans.
  task automatic push_ascending_table(input int unsigned n);
    longint      gaps [MaxPointsDef];
    longint      total;
    longint      key;
    int unsigned scale;
    scale = $urandom_range(0, 26);
    total = 0;
    for (int s = 1; s < n; s++) begin
      gaps[s] = longint'($urandom_range(1, (32'd1 << scale)));
      total  += gaps[s];
    end
    key = -64'sd2147483648 + longint'($urandom_range(0, 32'(64'hFFFF_FFFF - total)));
    for (int s = 0; s < n; s++) begin
      if (s > 0) key += gaps[s];
      push_write(s, KeyW'(key), random_channel(), random_channel(), random_channel(),
                 random_channel());
    end
  endtask

  // Most values fall inside the span of the keys in use, many sit right on a
  // key or one off it, and the rest are extremes or fully random.
  function automatic logic signed [KeyW-1:0] pick_value(input int unsigned n);
    longint      lo_k;
    longint      hi_k;
    longint      near;
    int unsigned roll;
    lo_k = plan_key[0];
    hi_k = plan_key[0];
    for (int s = 1; s < n; s++) begin
      if (plan_key[s] < lo_k) lo_k = plan_key[s];
      if (plan_key[s] > hi_k) hi_k = plan_key[s];
    end
    roll = $urandom_range(0, 9);
    if (roll < 5) return KeyW'(lo_k + longint'($urandom_range(0, 32'(hi_k - lo_k))));
    if (roll < 8) begin
      near = longint'(plan_key[$urandom_range(0, n - 1)]);
      return KeyW'(near + longint'($urandom_range(0, 2)) - 1);
    end
    if (roll == 8) return ($urandom_range(0, 1) != 0) ? KEY_MAX : KEY_MIN;
    return KeyW'($urandom);
  endfunction

  // Waits until every request has gone in and every colour has come back,
  // then lets the block settle.
  task automatic drain();
    while (pending_points.size() != 0 || lookup_bus.valid || expected_colours.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the point count; only called while the block is idle.
  task automatic write_point_count(input logic [CountW-1:0] count);
    cfg_bus.point_count <= count;
    cfg_bus.valid       <= 1'b1;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    model_count = count;
    settings_done++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  // A new request is offered only when the slot is free: nothing is offered,
  // or the current request is being taken at this edge. A random gap may follow
  // any request until the quiet part at the end.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      lookup_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (lookup_bus.valid && lookup_bus.ready) begin
        absorb_request(offered_req);
      end
      if (!lookup_bus.valid || lookup_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          lookup_bus.valid <= 1'b0;
        end else if (pending_points.size() != 0) begin
          offered_req = pending_points.pop_front();
          lookup_bus.valid        <= 1'b1;
          lookup_bus.op           <= offered_req.op;
          lookup_bus.entry_index  <= offered_req.slot;
          lookup_bus.key_or_value <= offered_req.key;
          lookup_bus.in_red       <= offered_req.red;
          lookup_bus.in_green     <= offered_req.green;
          lookup_bus.in_blue      <= offered_req.blue;
          lookup_bus.in_alpha     <= offered_req.alpha;
          if (!no_idle && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 17);
        end else begin
          lookup_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Colour monitor and receiver stalls
  // --------------------------------------------------------------------------
  // Every colour taken is checked field by field against the oldest
  // prediction. Ready drops in random bursts, and stays low for the whole
  // long hold-off that fills the block up.
  always @(posedge clk_i) begin
    rgba_t want;
    if (!rst_ni) begin
      colour_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (colour_bus.valid && colour_bus.ready) begin
        if (expected_colours.size() == 0) begin
          report_mismatch("colour with no lookup outstanding", 1, 0);
        end else begin
          want = expected_colours.pop_front();
          colours_checked++;
          if (colour_bus.out_red !== want.red)
            report_mismatch("out_red", colour_bus.out_red, want.red);
          if (colour_bus.out_green !== want.green)
            report_mismatch("out_green", colour_bus.out_green, want.green);
          if (colour_bus.out_blue !== want.blue)
            report_mismatch("out_blue", colour_bus.out_blue, want.blue);
          if (colour_bus.out_alpha !== want.alpha)
            report_mismatch("out_alpha", colour_bus.out_alpha, want.alpha);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        colour_bus.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        colour_bus.ready <= 1'b0;
      end else begin
        colour_bus.ready <= !hold_rsp;
      end
    end
  end

  // The long hold-off is counted here, apart from the monitor, once the
  // stimulus arms it.
  initial begin
    hold_rsp = 1'b0;
    wait (pressure_armed);
    @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned n;
    int unsigned roll;

    // Every input of the block starts from a known value.
    rst_ni                  = 1'b0;
    lookup_bus.valid        = 1'b0;
    lookup_bus.op           = OP_WRITE_POINT;
    lookup_bus.entry_index  = '0;
    lookup_bus.key_or_value = '0;
    lookup_bus.in_red       = '0;
    lookup_bus.in_green     = '0;
    lookup_bus.in_blue      = '0;
    lookup_bus.in_alpha     = '0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.point_count     = '0;
    colour_bus.ready        = 1'b0;
    no_idle                 = 1'b0;
    pressure_armed          = 1'b0;
    model_count             = CountW'(1);
    for (int s = 0; s < MaxPointsDef; s++) begin
      model_key[s]    = '0;
      model_rgba[s]   = '0;
      plan_key[s]     = '0;
      plan_written[s] = 1'b0;
    end
    phase_counts = '{5'd16, 5'd2, 5'd31, 5'd1, 5'd9, 5'd0, 5'd16, 5'd17, 5'd3, 5'd12};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The count is left at its reset value of one first, so
    // only slot 0 is ever read: both extremes and a value equal to its key
    // all return its colour unchanged.
    push_write(0, '0, 8'd10, 8'd20, 8'd30, 8'd40);
    push_lookup(KEY_MIN);
    push_lookup(KEY_MAX);
    push_lookup('0);
    drain();

    // A count of zero behaves as a single point.
    write_point_count(CountW'(0));
    push_lookup(-32'sd1);
    push_lookup(32'sd1);
    drain();

    // Two points at the key extremes, so the span is the widest there is and
    // the channels swing between 0 and 255 in both directions. A value equal
    // to the lower key interpolates with a zero fraction, one just below the
    // upper key with the largest fraction. A write to the last slot is
    // outside the points in use and must not disturb anything.
    write_point_count(CountW'(2));
    push_write(0, KEY_MIN, 8'd0, 8'd255, 8'd0, 8'd255);
    push_write(1, KEY_MAX, 8'd255, 8'd0, 8'd255, 8'd0);
    push_write(MaxPointsDef - 1, 32'sd12345, 8'd1, 8'd2, 8'd3, 8'd4);
    push_lookup(KEY_MIN);
    push_lookup('0);
    push_lookup(KEY_MAX - 1);
    push_lookup(KEY_MAX);
    drain();

    // Keys out of order: a third point below the second one. The scan still
    // stops at the first key above the value, and a value at the top runs
    // past every key and takes the last colour.
    write_point_count(CountW'(3));
    push_write(2, '0, 8'd128, 8'd64, 8'd32, 8'd16);
    push_lookup(-32'sd5);
    push_lookup(KEY_MAX);
    push_lookup('0);

    // Random part, one point-count setting per phase. Each phase makes sure
    // every slot in use is written, then mixes lookups with fresh ascending
    // tables and stray writes that break the ordering.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == NUM_PHASES - 1) no_idle <= 1'b1;
      write_point_count(phase_counts[p]);
      n = points_in_use(phase_counts[p]);
      if ($urandom_range(0, 2) != 0) push_ascending_table(n);
      for (int s = 0; s < n; s++) begin
        if (!plan_written[s]) begin
          push_write(s, KeyW'($urandom), random_channel(), random_channel(),
                     random_channel(), random_channel());
        end
      end
      // The receiver holds off while the lookups of this phase keep coming.
      if (p == PRESSURE_PHASE) pressure_armed <= 1'b1;
      for (int k = 0; k < PHASE_ROLLS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 72) push_lookup(pick_value(n));
        else if (roll < 82) push_ascending_table(n);
        else push_random_write();
      end
    end
    drain();

    $display("Covered %0d point writes and %0d lookups over %0d point-count settings.",
             writes_done, lookups_done, settings_done);
    $display("%0d colours compared, %0d mismatches.", colours_checked, error_count);
    if (error_count == 0) begin
      $display("piecewise_linear_colour_map verification clean");
    end else begin
      $display("piecewise_linear_colour_map verification failed");
    end
    $finish;
  end

endmodule
